/* rtl/core/cosine_angular_distance_unit_defines.svh */
// ---------------------------------------------------------------------------
// cosine angular distance unit assertion macros
// shared concurrent assertion forms for the rtl/core modules
// ---------------------------------------------------------------------------
`ifndef COSINE_ANGULAR_DISTANCE_UNIT_DEFINES_SVH
`define COSINE_ANGULAR_DISTANCE_UNIT_DEFINES_SVH

// property checked at every clock edge outside reset
`define CADU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define CADU_ASSERT_NEXT(label, cond, nxt, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (nxt)) else $error(msg);

`endif

/* rtl/core/cadu_pkg.sv */
// ---------------------------------------------------------------------------
// cadu_pkg
// types and constants shared by the cosine angular distance unit
// ---------------------------------------------------------------------------
package cadu_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int PROD_W      = 48;
   localparam int ACC_W       = 64;
   localparam int ANGLE_W     = 17;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [ACC_W-1:0]   Q30_ONE   = 64'h0000_0000_4000_0000;
   localparam logic [ACC_W-1:0]   TOP_BIT   = 64'h4000_0000_0000_0000;
   localparam logic [ANGLE_W-1:0] ANGLE_ONE = 17'h1_0000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sim_value;
      logic signed [SAMPLE_W-1:0] ref_value;
      logic                       last;
   } req_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle_frac;
      logic               zero_length;
   } rsp_type;

   // accumulated sums of one finished vector
   typedef struct packed {
      logic signed [ACC_W-1:0] dot;
      logic [ACC_W-1:0]        sim_norm;
      logic [ACC_W-1:0]        ref_norm;
   } job_type;

   // acos(x) / (pi * sqrt(1 - x)) polynomial, q30
   function automatic logic signed [31:0] poly_coef(input logic [2:0] idx);
      case (idx)
         3'd0:    poly_coef = 32'sd536870905;
         3'd1:    poly_coef = -32'sd73346144;
         3'd2:    poly_coef = 32'sd30411474;
         3'd3:    poly_coef = -32'sd17148706;
         3'd4:    poly_coef = 32'sd10558309;
         3'd5:    poly_coef = -32'sd5840424;
         3'd6:    poly_coef = 32'sd2279721;
         default: poly_coef = -32'sd431498;
      endcase
   endfunction

endpackage

/* rtl/core/cadu_front.sv */
// ---------------------------------------------------------------------------
// cadu_front
// takes element pairs, forms products and accumulates the three sums
// ---------------------------------------------------------------------------
module cadu_front #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  cadu_pkg::req_type             req_data,
   input  logic [cadu_pkg::QCNT_W-1:0]   queue_count,
   output logic                          push_valid,
   output cadu_pkg::job_type             push_job
);
   import cadu_pkg::*;

   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     a_valid_ff;
   logic                     a_last_ff, a_use_ff;
   logic signed [PROD_W-1:0] a_dot_ff;
   logic [PROD_W-1:0]        a_sim_ff, a_ref_ff;
   logic signed [ACC_W-1:0]  acc_dot_ff, acc_dot_in, sum_dot;
   logic [ACC_W-1:0]         acc_sim_ff, acc_sim_in, sum_sim;
   logic [ACC_W-1:0]         acc_ref_ff, acc_ref_in, sum_ref;
   logic                     accept, use_pair;
   logic signed [PROD_W-1:0] mul_dot, mul_sim, mul_ref;

   // room for the vector in flight keeps the push from ever blocking
   assign req_stall = (queue_count == QCNT_W'(QUEUE_DEPTH)) ||
                      ((queue_count == QCNT_W'(QUEUE_DEPTH - 1)) && a_valid_ff && a_last_ff);
   assign accept    = req_valid && !req_stall;
   assign use_pair  = count_ff < CNT_W'(MAX_ELEMENTS);

   assign mul_dot = req_data.sim_value * req_data.ref_value;
   assign mul_sim = req_data.sim_value * req_data.sim_value;
   assign mul_ref = req_data.ref_value * req_data.ref_value;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_data.last) begin
            count_in = '0;
         end else if (use_pair) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   assign sum_dot = acc_dot_ff + (a_use_ff ? ACC_W'(a_dot_ff) : '0);
   assign sum_sim = acc_sim_ff + (a_use_ff ? {16'b0, a_sim_ff} : '0);
   assign sum_ref = acc_ref_ff + (a_use_ff ? {16'b0, a_ref_ff} : '0);

   always_comb begin
      acc_dot_in = acc_dot_ff;
      acc_sim_in = acc_sim_ff;
      acc_ref_in = acc_ref_ff;
      if (a_valid_ff) begin
         if (a_last_ff) begin
            acc_dot_in = '0;
            acc_sim_in = '0;
            acc_ref_in = '0;
         end else begin
            acc_dot_in = sum_dot;
            acc_sim_in = sum_sim;
            acc_ref_in = sum_ref;
         end
      end
   end

   assign push_valid        = a_valid_ff && a_last_ff;
   assign push_job.dot      = sum_dot;
   assign push_job.sim_norm = sum_sim;
   assign push_job.ref_norm = sum_ref;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         a_valid_ff <= 1'b0;
         acc_dot_ff <= '0;
         acc_sim_ff <= '0;
         acc_ref_ff <= '0;
      end else begin
         count_ff   <= count_in;
         a_valid_ff <= accept;
         acc_dot_ff <= acc_dot_in;
         acc_sim_ff <= acc_sim_in;
         acc_ref_ff <= acc_ref_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_last_ff <= req_data.last;
         a_use_ff  <= use_pair;
         a_dot_ff  <= mul_dot;
         a_sim_ff  <= mul_sim;
         a_ref_ff  <= mul_ref;
      end
   end

endmodule

/* rtl/core/cadu_queue.sv */
// ---------------------------------------------------------------------------
// cadu_queue
// short queue of finished vector sums between front and back
// ---------------------------------------------------------------------------
`include "cosine_angular_distance_unit_defines.svh"

module cadu_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  cadu_pkg::job_type           push_job,
   input  logic                        pop,
   output cadu_pkg::job_type           head_job,
   output logic [cadu_pkg::QCNT_W-1:0] queue_count
);
   import cadu_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign head_job    = entry_ff[rd_ptr_ff];
   assign queue_count = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `CADU_ASSERT(a_no_overflow, !push_valid || pop || (count_ff != QCNT_W'(QUEUE_DEPTH)), "queue push while full")
   `CADU_ASSERT(a_no_underflow, !pop || (count_ff != '0), "queue pop while empty")
   `CADU_ASSERT_NEXT(a_count_up, push_valid && !pop, count_ff == $past(count_ff) + QCNT_W'(1), "queue count lost a push")

endmodule

/* rtl/core/cadu_back.sv */
// ---------------------------------------------------------------------------
// cadu_back
// sequencer that turns vector sums into angle over pi
// ---------------------------------------------------------------------------
`include "cosine_angular_distance_unit_defines.svh"

module cadu_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   input  cadu_pkg::job_type           job,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output cadu_pkg::rsp_type           rsp_data
);
   import cadu_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_NORM  = 12'b0000_0000_0010,
      ST_ROOT  = 12'b0000_0000_0100,
      ST_DEN   = 12'b0000_0000_1000,
      ST_CMP   = 12'b0000_0001_0000,
      ST_DIV   = 12'b0000_0010_0000,
      ST_PMUL  = 12'b0000_0100_0000,
      ST_PADD  = 12'b0000_1000_0000,
      ST_ROOT2 = 12'b0001_0000_0000,
      ST_AMUL  = 12'b0010_0000_0000,
      ST_AFIN  = 12'b0100_0000_0000,
      ST_DONE  = 12'b1000_0000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [ACC_W-1:0]     sn_ff, sn_in, rn_ff, rn_in, num_ff, num_in;
   logic [ACC_W-1:0]     ra_ff, ra_in, rb_ff, rb_in, bit_ff, bit_in;
   logic [ACC_W-1:0]     den_ff, den_in, prod_ff, prod_in;
   logic [4:0]           step_ff, step_in;
   logic [30:0]          c_ff, c_in;
   logic signed [31:0]   p_ff, p_in;
   logic [2:0]           idx_ff, idx_in;
   logic                 neg_ff, neg_in, pneg_ff, pneg_in;
   logic [ANGLE_W-1:0]   fin_ff, fin_in;
   logic                 zl_ff, zl_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic [ACC_W-1:0]     ta, tb, mag, shl, rnd, a_base;
   logic                 ge_a, ge_b, ls, lr, take, out_free;
   logic [31:0]          pmag;
   logic [33:0]          m;
   logic signed [35:0]   p_sum;
   logic [30:0]          a_clip, a_fin;
   logic [31:0]          a_round;

   // one step of the digit-by-digit square root, two units side by side
   assign ta   = ra_ff + bit_ff;
   assign tb   = rb_ff + bit_ff;
   assign ge_a = sn_ff >= ta;
   assign ge_b = rn_ff >= tb;

   assign ls   = sn_ff[63:62] == 2'b00;
   assign lr   = rn_ff[63:62] == 2'b00;
   assign mag  = job.dot[63] ? (64'd0 - job.dot) : job.dot;

   // restoring divide step, the carry covers the bit shifted out
   assign shl  = {num_ff[62:0], 1'b0};
   assign take = num_ff[63] || (shl >= den_ff);

   assign pmag  = p_ff[31] ? (32'd0 - p_ff) : p_ff;
   assign rnd   = prod_ff + 64'h0000_0000_2000_0000;
   assign m     = rnd[63:30];
   assign p_sum = (pneg_ff ? (36'sd0 - $signed({2'b00, m})) : $signed({2'b00, m})) +
                  36'(poly_coef(idx_ff));

   assign a_base  = (Q30_ONE - {33'b0, c_ff}) << 30;
   assign a_clip  = (pneg_ff && (m != '0)) ? 31'd0 :
                    (m > 34'h0_4000_0000) ? 31'h4000_0000 : m[30:0];
   assign a_fin   = neg_ff ? (31'h4000_0000 - a_clip) : a_clip;
   assign a_round = {1'b0, a_fin} + 32'h0000_2000;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == ST_IDLE) && job_valid;

   always_comb begin
      state_in = state_ff;
      sn_in    = sn_ff;
      rn_in    = rn_ff;
      num_in   = num_ff;
      ra_in    = ra_ff;
      rb_in    = rb_ff;
      bit_in   = bit_ff;
      den_in   = den_ff;
      prod_in  = prod_ff;
      step_in  = step_ff;
      c_in     = c_ff;
      p_in     = p_ff;
      idx_in   = idx_ff;
      neg_in   = neg_ff;
      pneg_in  = pneg_ff;
      fin_in   = fin_ff;
      zl_in    = zl_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               neg_in = job.dot[63];
               sn_in  = job.sim_norm;
               rn_in  = job.ref_norm;
               num_in = mag;
               zl_in  = 1'b0;
               if ((job.sim_norm == '0) || (job.ref_norm == '0)) begin
                  fin_in   = ANGLE_ONE;
                  zl_in    = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_NORM;
               end
            end
         end
         ST_NORM: begin
            if (ls) begin
               sn_in = sn_ff << 2;
            end
            if (lr) begin
               rn_in = rn_ff << 2;
            end
            case ({ls, lr}) inside
               2'b11:   num_in = num_ff << 2;
               2'b10,
               2'b01:   num_in = num_ff << 1;
               default: num_in = num_ff;
            endcase
            if (!ls && !lr) begin
               ra_in    = '0;
               rb_in    = '0;
               bit_in   = TOP_BIT;
               step_in  = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            sn_in   = ge_a ? (sn_ff - ta) : sn_ff;
            ra_in   = ge_a ? ((ra_ff >> 1) + bit_ff) : (ra_ff >> 1);
            rn_in   = ge_b ? (rn_ff - tb) : rn_ff;
            rb_in   = ge_b ? ((rb_ff >> 1) + bit_ff) : (rb_ff >> 1);
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               state_in = ST_DEN;
            end
         end
         ST_DEN: begin
            den_in   = ra_ff[31:0] * rb_ff[31:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            step_in = '0;
            if (num_ff >= den_ff) begin
               c_in     = 31'h4000_0000;
               p_in     = poly_coef(3'd7);
               idx_in   = 3'd6;
               state_in = ST_PMUL;
            end else begin
               c_in     = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            num_in  = take ? (shl - den_ff) : shl;
            c_in    = {1'b0, c_ff[28:0], take};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd29) begin
               p_in     = poly_coef(3'd7);
               idx_in   = 3'd6;
               state_in = ST_PMUL;
            end
         end
         ST_PMUL: begin
            prod_in  = pmag * {1'b0, c_ff};
            pneg_in  = p_ff[31];
            state_in = ST_PADD;
         end
         ST_PADD: begin
            p_in = p_sum[31:0];
            if (idx_ff == 3'd0) begin
               sn_in    = a_base;
               ra_in    = '0;
               bit_in   = TOP_BIT;
               step_in  = '0;
               state_in = ST_ROOT2;
            end else begin
               idx_in   = idx_ff - 3'd1;
               state_in = ST_PMUL;
            end
         end
         ST_ROOT2: begin
            sn_in   = ge_a ? (sn_ff - ta) : sn_ff;
            ra_in   = ge_a ? ((ra_ff >> 1) + bit_ff) : (ra_ff >> 1);
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               state_in = ST_AMUL;
            end
         end
         ST_AMUL: begin
            prod_in  = ra_ff[31:0] * pmag;
            pneg_in  = p_ff[31];
            state_in = ST_AFIN;
         end
         ST_AFIN: begin
            fin_in   = a_round[30:14];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sn_ff   <= sn_in;
      rn_ff   <= rn_in;
      num_ff  <= num_in;
      ra_ff   <= ra_in;
      rb_ff   <= rb_in;
      bit_ff  <= bit_in;
      den_ff  <= den_in;
      prod_ff <= prod_in;
      step_ff <= step_in;
      c_ff    <= c_in;
      p_ff    <= p_in;
      idx_ff  <= idx_in;
      neg_ff  <= neg_in;
      pneg_ff <= pneg_in;
      fin_ff  <= fin_in;
      zl_ff   <= zl_in;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_ff.angle_frac  <= fin_ff;
         rsp_ff.zero_length <= zl_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CADU_ASSERT(a_zero_len_full, !rsp_valid_ff || !rsp_ff.zero_length || (rsp_ff.angle_frac == ANGLE_ONE), "zero norm result is not full angle")
   `CADU_ASSERT(a_angle_range, !rsp_valid_ff || (rsp_ff.angle_frac <= ANGLE_ONE), "angle above one")
   `CADU_ASSERT_NEXT(a_rsp_hold, rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(rsp_ff), "stalled result changed")

endmodule

/* rtl/core/cosine_angular_distance_unit.sv */
// flow: each accepted pair's products are registered, then added into the sums; a vector
//   with a zero norm goes straight to its result, else through normalize, two 32-step roots,
//   a 30-step divide unless clamped and 7 polynomial steps
// throughput: one element pair per cycle while req_stall is low; the two-entry queue lets
//   the next vector accumulate while the angle sequencer works on an earlier one
// reset: synchronous, active high; clears the sums, the count, the queue and the sequencer
// ---------------------------------------------------------------------------
// cosine_angular_distance_unit
// streams element pairs and reports the angle between the two vectors over pi
// ---------------------------------------------------------------------------
module cosine_angular_distance_unit #(
   parameter int MAX_ELEMENTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   // element pair transactions
   input  logic              req_valid,
   output logic              req_stall,
   input  cadu_pkg::req_type req_data,
   // one result transaction per vector
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cadu_pkg::rsp_type rsp_data
);
   import cadu_pkg::*;

   logic                push_valid;
   job_type             push_job;
   job_type             head_job;
   logic [QCNT_W-1:0]   queue_count;
   logic                pop;

   // front end: products registered, then the three sums; the last pair
   // pushes the finished sums into the queue and clears them
   cadu_front #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .queue_count (queue_count),
      .push_valid  (push_valid),
      .push_job    (push_job)
   );

   // decouples accumulation of the next vector from the angle work
   cadu_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_job    (push_job),
      .pop         (pop),
      .head_job    (head_job),
      .queue_count (queue_count)
   );

   // back end: sequencer with square root, divide and polynomial steps,
   // result held in an output register
   cadu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_count != '0),
      .job       (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
